// ----- src/rpr_pkg.sv -----
// ----------------------------------------------------------------------------
// rpr_pkg: shared types and constants of the request packet receiver
// Status codes, configuration register indexes and the records that move
// between the receiver's stages.
// ----------------------------------------------------------------------------
`default_nettype none

package rpr_pkg;

  localparam int PacketLenDefault = 8;

  localparam int HeaderW  = 32;
  localparam int TimeoutW = 16;
  localparam int SumW     = 16;
  localparam int ByteW    = 8;
  localparam int CfgDataW = 32;
  localparam int CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgIdxHeader  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxTimeout = 1'd1;

  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd5;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CSUM    = 2'd1,
    STATUS_HDR     = 2'd2,
    STATUS_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [HeaderW-1:0]  header;
    logic [TimeoutW-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    cmd_e             cmd;
    logic [ByteW-1:0] data;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] mode;
    logic [ByteW-1:0] reps;
    logic             setup_valid;
  } result_t;

endpackage

`default_nettype wire

// ----- src/rpr_if.sv -----
// ----------------------------------------------------------------------------
// rpr_req_if / rpr_res_if: request and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpr_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface rpr_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] mode;
  logic [7:0] reps;
  logic       setup_valid;

  modport source (output valid, output status, output mode, output reps,
                  output setup_valid, input ready);
  modport sink   (input valid, input status, input mode, input reps,
                  input setup_valid, output ready);
endinterface

`default_nettype wire

// ----- src/rpr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rpr_cfg_regs: configuration registers
// Holds the expected request header and the timeout in ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [rpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rpr_pkg::CfgDataW-1:0] cfg_data_i,
  output rpr_pkg::cfg_t                     cfg_o
);

  logic [rpr_pkg::HeaderW-1:0]  header_q;
  logic [rpr_pkg::TimeoutW-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= '0;
      timeout_q <= rpr_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpr_pkg::CfgIdxHeader:  header_q  <= cfg_data_i[rpr_pkg::HeaderW-1:0];
        rpr_pkg::CfgIdxTimeout: timeout_q <= cfg_data_i[rpr_pkg::TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.header  = header_q;
  assign cfg_o.timeout = timeout_q;

endmodule

`default_nettype wire

// ----- src/rpr_in_stage.sv -----
// ----------------------------------------------------------------------------
// rpr_in_stage: request input register
// Captures one request per cycle unless stalled; holds it until parsed.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_in_stage (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rpr_req_if.sink    req,
  input  wire logic  advance_i,
  output rpr_pkg::item_t item_o
);

  logic                          valid_q, valid_d;
  rpr_pkg::cmd_e                 cmd_q;
  logic [rpr_pkg::ByteW-1:0]     data_q;
  logic                          load;

  assign req.ready = !valid_q || advance_i;
  assign load      = req.valid && req.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= rpr_pkg::cmd_e'(req.command);
      data_q <= req.data_byte;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.cmd   = cmd_q;
  assign item_o.data  = data_q;

endmodule

`default_nettype wire

// ----- src/rpr_parser.sv -----
// ----------------------------------------------------------------------------
// rpr_parser: packet state and checks
// Tracks byte position, running sum, header match and tick timeout, and
// produces the result for the last byte of a packet or a timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_parser #(
  parameter int PACKET_LEN = rpr_pkg::PacketLenDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rpr_pkg::cfg_t   cfg_i,
  input  wire rpr_pkg::item_t  item_i,
  input  wire logic            out_free_i,
  output logic                 advance_o,
  output logic                 res_load_o,
  output rpr_pkg::result_t     res_o
);

  localparam int PosW = $clog2(PACKET_LEN);
  localparam logic [PosW-1:0] PosCsumHi = PosW'(PACKET_LEN - 2);
  localparam logic [PosW-1:0] PosMode   = PosW'(4);
  localparam logic [PosW-1:0] PosReps   = PosW'(5);

  logic [PosW-1:0]              pos_q, pos_d;
  logic [rpr_pkg::SumW-1:0]     sum_q, sum_d;
  logic                         hdr_ok_q, hdr_ok_d;
  logic [rpr_pkg::ByteW-1:0]    pmode_q, pmode_d;
  logic [rpr_pkg::ByteW-1:0]    preps_q, preps_d;
  logic [rpr_pkg::ByteW-1:0]    csum_hi_q, csum_hi_d;
  logic [rpr_pkg::TimeoutW-1:0] elapsed_q, elapsed_d;
  logic [rpr_pkg::ByteW-1:0]    lmode_q, lmode_d;
  logic [rpr_pkg::ByteW-1:0]    lreps_q, lreps_d;
  logic                         setup_q, setup_d;

  logic                         has_result;
  rpr_pkg::status_e             status;
  logic                         fire;
  logic [1:0]                   hdr_sel;
  logic [rpr_pkg::ByteW-1:0]    hdr_byte;
  logic [rpr_pkg::TimeoutW-1:0] elapsed_inc;
  logic [rpr_pkg::SumW-1:0]     check;

  // first header byte sits in the top byte of the register
  assign hdr_sel  = 2'd3 - pos_q[1:0];
  assign hdr_byte = cfg_i.header[{hdr_sel, 3'b000} +: rpr_pkg::ByteW];
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign check    = {csum_hi_q, item_i.data};

  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    hdr_ok_d   = hdr_ok_q;
    pmode_d    = pmode_q;
    preps_d    = preps_q;
    csum_hi_d  = csum_hi_q;
    elapsed_d  = elapsed_q;
    lmode_d    = lmode_q;
    lreps_d    = lreps_q;
    setup_d    = setup_q;
    has_result = 1'b0;
    status     = rpr_pkg::STATUS_OK;

    if (item_i.cmd == rpr_pkg::CMD_TICK) begin
      if (pos_q != '0) begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc > cfg_i.timeout) begin
          // drop the partial packet
          pos_d      = '0;
          sum_d      = '0;
          hdr_ok_d   = 1'b1;
          pmode_d    = '0;
          preps_d    = '0;
          csum_hi_d  = '0;
          elapsed_d  = '0;
          has_result = 1'b1;
          status     = rpr_pkg::STATUS_TIMEOUT;
        end
      end
    end else begin
      if (pos_q == '0) begin
        elapsed_d = '0;
      end
      if (pos_q < PosMode && item_i.data != hdr_byte) begin
        hdr_ok_d = 1'b0;
      end
      if (pos_q == PosMode) begin
        pmode_d = item_i.data;
      end
      if (pos_q == PosReps) begin
        preps_d = item_i.data;
      end

      priority if (pos_q < PosCsumHi) begin
        sum_d = sum_q + {{(rpr_pkg::SumW - rpr_pkg::ByteW){1'b0}}, item_i.data};
        pos_d = pos_q + 1'b1;
      end else if (pos_q == PosCsumHi) begin
        csum_hi_d = item_i.data;
        pos_d     = pos_q + 1'b1;
      end else begin
        has_result = 1'b1;
        priority if (check != sum_q) begin
          status = rpr_pkg::STATUS_CSUM;
        end else if (!hdr_ok_q) begin
          status = rpr_pkg::STATUS_HDR;
        end else begin
          status  = rpr_pkg::STATUS_OK;
          lmode_d = pmode_q;
          lreps_d = preps_q;
          setup_d = 1'b1;
        end
        pos_d     = '0;
        sum_d     = '0;
        hdr_ok_d  = 1'b1;
        pmode_d   = '0;
        preps_d   = '0;
        csum_hi_d = '0;
        elapsed_d = '0;
      end
    end
  end

  assign advance_o  = item_i.valid && (!has_result || out_free_i);
  assign fire       = advance_o;
  assign res_load_o = fire && has_result;

  assign res_o.status      = status;
  assign res_o.mode        = lmode_d;
  assign res_o.reps        = lreps_d;
  assign res_o.setup_valid = setup_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sum_q     <= '0;
      hdr_ok_q  <= 1'b1;
      pmode_q   <= '0;
      preps_q   <= '0;
      csum_hi_q <= '0;
      elapsed_q <= '0;
      lmode_q   <= '0;
      lreps_q   <= '0;
      setup_q   <= 1'b0;
    end else if (fire) begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      hdr_ok_q  <= hdr_ok_d;
      pmode_q   <= pmode_d;
      preps_q   <= preps_d;
      csum_hi_q <= csum_hi_d;
      elapsed_q <= elapsed_d;
      lmode_q   <= lmode_d;
      lreps_q   <= lreps_d;
      setup_q   <= setup_d;
    end
  end

  a_setup_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(setup_q))
    else $error("setup flag cleared");

  a_ok_sets_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load_o && status == rpr_pkg::STATUS_OK) |=> setup_q)
    else $error("accepted packet did not set setup flag");

  a_idle_no_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (elapsed_q == '0))
    else $error("tick count nonzero with no packet started");

  a_timeout_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load_o && status == rpr_pkg::STATUS_TIMEOUT) |-> (pos_q != '0))
    else $error("timeout reported with no partial packet");

  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |=> (pos_q == '0 && sum_q == '0))
    else $error("packet state not cleared after result");

endmodule

`default_nettype wire

// ----- src/rpr_out_stage.sv -----
// ----------------------------------------------------------------------------
// rpr_out_stage: result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rpr_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire rpr_pkg::result_t res_i,
  output logic                  free_o,
  rpr_res_if.source             res
);

  logic             valid_q, valid_d;
  rpr_pkg::result_t data_q;

  assign free_o = !valid_q || res.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign res.valid       = valid_q;
  assign res.status      = data_q.status;
  assign res.mode        = data_q.mode;
  assign res.reps        = data_q.reps;
  assign res.setup_valid = data_q.setup_valid;

endmodule

`default_nettype wire

// ----- src/request_packet_receiver_core.sv -----
// ----------------------------------------------------------------------------
// request_packet_receiver_core: fixed-length request packet receiver
// Deframes PACKET_LEN-byte requests with a 16-bit sum checksum and header.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one item per transfer: a received byte (command 0) or one
//   time tick (command 1). res_o gives one result for the last byte of each
//   packet (accepted, checksum mismatch, header mismatch) and for a partial
//   packet dropped on timeout; other items give no result.
//   Configuration: write index 0 for the expected header (first byte in bits
//   31..24) and index 1 for the timeout in ticks; write only while idle.
//   A request is held in the input register, checked by the combinational
//   parser and its result loaded into the output register once that register
//   is free, which raises res_o.valid.
//   Throughput: one request per cycle while no result waits for the result
//   slot; the parser between the input and output registers is combinational.
//   Reset clears the packet state, the latched mode and repetition count and
//   the setup flag; the header resets to 0 and the timeout to 5 ticks.
//   Stall: a waiting result holds in the output register; requests that give
//   no result keep flowing, and one that gives a result waits in the input
//   register with req_i.ready low until the result slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module request_packet_receiver_core #(
  parameter int PACKET_LEN = rpr_pkg::PacketLenDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  rpr_req_if.sink                           req_i,
  rpr_res_if.source                         res_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [rpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rpr_pkg::CfgDataW-1:0] cfg_data_i
);

  rpr_pkg::cfg_t    cfg;
  rpr_pkg::item_t   item;
  rpr_pkg::result_t result;
  logic             advance;
  logic             res_load;
  logic             out_free;

  rpr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rpr_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .advance_i (advance),
    .item_o    (item)
  );

  rpr_parser #(
    .PACKET_LEN (PACKET_LEN)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .item_i     (item),
    .out_free_i (out_free),
    .advance_o  (advance),
    .res_load_o (res_load),
    .res_o      (result)
  );

  rpr_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_load),
    .res_i  (result),
    .free_o (out_free),
    .res    (res_o)
  );

endmodule

`default_nettype wire
